/* src/plti_pkg.sv */
// shared types, codes and sizes for the piecewise-linear table interpolator
package plti_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int N_W         = $clog2(MAX_ENTRIES + 1);

  localparam int DIST_W = 18;
  localparam int TIME_W = 21;
  localparam int TT_W   = 23;
  localparam int DIV_W  = 40;
  localparam int DCNT_W = $clog2(DIV_W);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REJECT  = 1'd1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] ST_IN_RANGE = 2'd0;
  localparam logic [1:0] ST_EXTRAP   = 2'd1;
  localparam logic [1:0] ST_REJECT   = 2'd2;
  localparam logic [1:0] ST_ZERO_W   = 2'd3;

  localparam logic signed [TT_W-1:0] TT_MAX = {1'b0, {(TT_W-1){1'b1}}};
  localparam logic signed [TT_W-1:0] TT_MIN = {1'b1, {(TT_W-1){1'b0}}};

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] entry_index;
    logic [DIST_W-1:0] entry_distance;
    logic [TIME_W-1:0] entry_time;
    logic [DIST_W-1:0] query_distance;
  } in_item_t;

  typedef struct packed {
    logic signed [TT_W-1:0] travel_time;
    logic [1:0]             status;
  } out_item_t;

  // decoded work item between front and back
  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] addr;
    logic [DIST_W-1:0] dval;
    logic [TIME_W-1:0] tval;
  } cmd_t;

  typedef struct packed {
    logic [DIST_W-1:0] dval;
    logic [TIME_W-1:0] tval;
  } entry_t;

  // per-query settings handed to the back end
  typedef struct packed {
    logic              reject;
    logic [ADDR_W-1:0] last_idx;
  } ctl_t;

endpackage

/* src/plti_front.sv */
// input stage: takes requests, decodes them into commands for the queue
module plti_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  plti_pkg::in_item_t in_data,
  output logic               push,
  output plti_pkg::cmd_t     push_cmd,
  input  logic               q_full
);
  import plti_pkg::*;

  logic hold_valid_r, hold_valid_nxt;
  cmd_t hold_r, hold_nxt;
  logic take;

  assign in_stall = hold_valid_r && q_full;
  assign take     = in_valid && !in_stall;
  assign push     = hold_valid_r && !q_full;
  assign push_cmd = hold_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    if (push) hold_valid_nxt = 1'b0;
    if (take) begin
      hold_valid_nxt = 1'b1;
      hold_nxt.op    = in_data.kind;
      hold_nxt.addr  = in_data.entry_index;
      hold_nxt.tval  = in_data.entry_time;
      // a query carries its distance in the same slot a load uses
      hold_nxt.dval  = (in_data.kind == OP_QUERY) ? in_data.query_distance
                                                  : in_data.entry_distance;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
    hold_r <= hold_nxt;
  end

endmodule

/* src/plti_queue.sv */
// short command queue between the front and back ends
module plti_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  plti_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output plti_pkg::cmd_t head
);
  import plti_pkg::*;

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full      = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) slot_r[wr_ptr_r] <= push_cmd;
  end

endmodule

/* src/plti_back.sv */
// back end: table memory, linear search, interpolation divide and result register
module plti_back (
  input  logic                clk,
  input  logic                rst_n,
  input  plti_pkg::ctl_t      ctl,
  input  logic                q_not_empty,
  input  plti_pkg::cmd_t      q_head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output plti_pkg::out_item_t out_data
);
  import plti_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRCH = 4'd1;
  localparam logic [3:0] S_F0   = 4'd2;
  localparam logic [3:0] S_F1   = 4'd3;
  localparam logic [3:0] S_F2   = 4'd4;
  localparam logic [3:0] S_DIFF = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_PREP = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;
  localparam logic [3:0] S_EMIT = 4'd10;

  localparam int DT_W  = TIME_W + 1;
  localparam int DD_W  = DIST_W + 1;
  localparam int NUM_W = DT_W + DD_W;
  localparam int SUM_W = DIV_W + 2;

  // table memory, one write and one registered read port
  entry_t            mem [MAX_ENTRIES];
  entry_t            rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;

  logic [3:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] seg_r, seg_nxt;
  logic [DIST_W-1:0] q_r, q_nxt;
  logic [DIST_W-1:0] prev_r, prev_nxt;
  logic [DIST_W-1:0] first_r, first_nxt;
  logic [1:0]        stat_r, stat_nxt;
  entry_t            e0_r, e0_nxt;
  entry_t            e1_r, e1_nxt;

  logic signed [DT_W-1:0]  dt_r, dt_nxt;
  logic signed [DD_W-1:0]  dd_r, dd_nxt;
  logic signed [DD_W-1:0]  dw_r, dw_nxt;
  logic signed [NUM_W-1:0] num_r, num_nxt;

  logic [DIV_W-1:0]  div_n_r, div_n_nxt;
  logic [DIST_W-1:0] div_d_r, div_d_nxt;
  logic [DIST_W-1:0] rem_r, rem_nxt;
  logic [DCNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic              neg_r, neg_nxt;

  logic signed [TT_W-1:0] res_time_r, res_time_nxt;
  logic [1:0]             res_stat_r, res_stat_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // scratch for the arithmetic steps
  logic [NUM_W-1:0]       an_full;
  logic [DD_W-1:0]        ad_full;
  logic [DIST_W:0]        rem_sh;
  logic                   rem_ge;
  logic signed [SUM_W-1:0] quo_s;
  logic signed [SUM_W-1:0] sum_s;
  logic                    hit;

  assign pop       = (state_r == S_IDLE) && q_not_empty;
  assign mem_we    = pop && (q_head.op == OP_LOAD);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[q_head.addr] <= '{dval: q_head.dval, tval: q_head.tval};
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    case (state_r)
      S_SRCH:  rd_addr = cnt_r + 1'b1;
      S_F0:    rd_addr = seg_r;
      S_F1:    rd_addr = seg_r + 1'b1;
      default: rd_addr = '0;
    endcase
  end

  assign hit = (q_r >= prev_r) && (q_r <= rd_data_r.dval);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    seg_nxt      = seg_r;
    q_nxt        = q_r;
    prev_nxt     = prev_r;
    first_nxt    = first_r;
    stat_nxt     = stat_r;
    e0_nxt       = e0_r;
    e1_nxt       = e1_r;
    dt_nxt       = dt_r;
    dd_nxt       = dd_r;
    dw_nxt       = dw_r;
    num_nxt      = num_r;
    div_n_nxt    = div_n_r;
    div_d_nxt    = div_d_r;
    rem_nxt      = rem_r;
    div_cnt_nxt  = div_cnt_r;
    neg_nxt      = neg_r;
    res_time_nxt = res_time_r;
    res_stat_nxt = res_stat_r;

    an_full = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
    ad_full = dw_r[DD_W-1] ? DD_W'(-dw_r) : DD_W'(dw_r);
    rem_sh  = {rem_r, div_n_r[DIV_W-1]};
    rem_ge  = (rem_sh >= {1'b0, div_d_r});
    quo_s   = neg_r ? -$signed({2'b00, div_n_r}) : $signed({2'b00, div_n_r});
    sum_s   = quo_s + $signed(SUM_W'(e0_r.tval));

    case (state_r)
      S_IDLE: begin
        if (pop && (q_head.op == OP_QUERY)) begin
          q_nxt     = q_head.dval;
          cnt_nxt   = '0;
          state_nxt = S_SRCH;
        end
      end
      // rd_data_r holds entry cnt_r; look for the first bracketing interval
      S_SRCH: begin
        prev_nxt = rd_data_r.dval;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == '0) begin
          first_nxt = rd_data_r.dval;
        end else if (hit) begin
          seg_nxt   = cnt_r - 1'b1;
          stat_nxt  = ST_IN_RANGE;
          state_nxt = S_F0;
        end else if (cnt_r == ctl.last_idx) begin
          if (ctl.reject) begin
            res_time_nxt = '0;
            res_stat_nxt = ST_REJECT;
            state_nxt    = S_EMIT;
          end else begin
            // below the table: first segment, otherwise the last used one
            seg_nxt   = (q_r < first_r) ? '0 : ctl.last_idx - 1'b1;
            stat_nxt  = ST_EXTRAP;
            state_nxt = S_F0;
          end
        end
      end
      S_F0: state_nxt = S_F1;
      S_F1: begin
        e0_nxt    = rd_data_r;
        state_nxt = S_F2;
      end
      S_F2: begin
        e1_nxt    = rd_data_r;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        dt_nxt    = $signed({1'b0, e1_r.tval}) - $signed({1'b0, e0_r.tval});
        dd_nxt    = $signed({1'b0, q_r}) - $signed({1'b0, e0_r.dval});
        dw_nxt    = $signed({1'b0, e1_r.dval}) - $signed({1'b0, e0_r.dval});
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (dw_r == '0) begin
          // zero-width interval saturates toward the sign of dt*dd, or gives e0's time when dt or dd is zero
          res_stat_nxt = ST_ZERO_W;
          if ((dt_r == '0) || (dd_r == '0)) res_time_nxt = TT_W'(e0_r.tval);
          else res_time_nxt = (dt_r[DT_W-1] == dd_r[DD_W-1]) ? TT_MAX : TT_MIN;
          state_nxt = S_EMIT;
        end else begin
          num_nxt   = dt_r * dd_r;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        neg_nxt     = num_r[NUM_W-1] ^ dw_r[DD_W-1];
        div_d_nxt   = ad_full[DIST_W-1:0];
        // half the divisor added up front gives round-half-away
        div_n_nxt   = an_full[DIV_W-1:0] + DIV_W'(ad_full[DIST_W-1:1]);
        rem_nxt     = '0;
        div_cnt_nxt = '0;
        state_nxt   = S_DIV;
      end
      // restoring divide, one quotient bit per cycle
      S_DIV: begin
        rem_nxt     = rem_ge ? DIST_W'(rem_sh - {1'b0, div_d_r}) : rem_sh[DIST_W-1:0];
        div_n_nxt   = {div_n_r[DIV_W-2:0], rem_ge};
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DCNT_W'(DIV_W-1)) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sum_s > SUM_W'(TT_MAX)) res_time_nxt = TT_MAX;
        else if (sum_s < SUM_W'(TT_MIN)) res_time_nxt = TT_MIN;
        else res_time_nxt = sum_s[TT_W-1:0];
        res_stat_nxt = stat_r;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if ((state_r == S_EMIT) && (!out_valid_r || !out_stall)) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.travel_time = res_time_r;
      out_data_nxt.status      = res_stat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    cnt_r      <= cnt_nxt;
    seg_r      <= seg_nxt;
    q_r        <= q_nxt;
    prev_r     <= prev_nxt;
    first_r    <= first_nxt;
    stat_r     <= stat_nxt;
    e0_r       <= e0_nxt;
    e1_r       <= e1_nxt;
    dt_r       <= dt_nxt;
    dd_r       <= dd_nxt;
    dw_r       <= dw_nxt;
    num_r      <= num_nxt;
    div_n_r    <= div_n_nxt;
    div_d_r    <= div_d_nxt;
    rem_r      <= rem_nxt;
    div_cnt_r  <= div_cnt_nxt;
    neg_r      <= neg_nxt;
    res_time_r <= res_time_nxt;
    res_stat_r <= res_stat_nxt;
  end

endmodule

/* src/piecewise_linear_table_interp.sv */
// top level of the piecewise-linear distance-to-time lookup table
// Piecewise-linear lookup table: load requests write one (distance, time)
// pair of a 256-entry table, query requests return the interpolated time for
// a distance, all in 1/1024 units. A query is matched by a linear search for
// the first interval that brackets it, then rounded-to-nearest interpolation
// through a serial divider. Out-of-range queries are rejected (status 2) or
// extrapolated from the first or last used segment (status 1); a zero-width
// interval gives status 3 and a saturated time, or the segment's start time
// when dt or dd is zero. Table entries are not cleared by reset, so every
// entry a query can touch must be loaded first. A load is written as it is
// popped. A query's search reads one entry per cycle, up to the entries in
// use, from the single read port of the table memory, then the segment is
// fetched, the product is formed, the one-bit-per-cycle divider runs and
// the result is finished. Rejected and zero-width queries skip the divide.
// Requests are decoded by a front stage into a two-entry queue, so new
// requests keep being taken while a query runs until the queue and the
// front holding register are full, and the result register lets the back
// end compute the next result while the previous result is still waiting.
module piecewise_linear_table_interp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  plti_pkg::in_item_t                    in_data,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output plti_pkg::out_item_t                   out_data,
  // configuration writes
  input  logic                                  cfg_we,
  input  logic [plti_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [plti_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import plti_pkg::*;

  // configuration registers
  logic [N_W-1:0] entries_r, entries_nxt;
  logic           reject_r, reject_nxt;
  logic [N_W-1:0] n_eff;
  ctl_t           ctl;

  // front to queue to back
  logic push, q_full, pop, q_not_empty;
  cmd_t push_cmd, q_head;

  always_comb begin
    entries_nxt = entries_r;
    reject_nxt  = reject_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_ENTRIES: entries_nxt = cfg_wdata[N_W-1:0];
        REG_REJECT:  reject_nxt  = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= N_W'(2);
      reject_r  <= 1'b0;
    end else begin
      entries_r <= entries_nxt;
      reject_r  <= reject_nxt;
    end
  end

  // entry count clamped to the usable range, handed on as the last index
  always_comb begin
    if (entries_r < N_W'(2)) n_eff = N_W'(2);
    else if (entries_r > N_W'(MAX_ENTRIES)) n_eff = N_W'(MAX_ENTRIES);
    else n_eff = entries_r;
  end

  assign ctl.reject   = reject_r;
  assign ctl.last_idx = ADDR_W'(n_eff - 1'b1);

  plti_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  plti_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  plti_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
